### hw/rtl/rational_arithmetic_unit_assert.svh
// Assertion macros for the rational arithmetic unit.
// Expects i_clk and i_rst_n in the scope of the module that includes it.
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RAU_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rau: check failed");

// next-cycle implication, checked out of reset
`define RAU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rau: check failed");

`endif

### hw/rtl/rau_pkg.sv
// Shared types, widths and helper functions of the rational arithmetic unit.
// No dependencies; used by rau_shared_unit and rational_arithmetic_unit.
`timescale 1ns / 1ps
`default_nettype none

package rau_pkg;

    // field widths of the ports
    localparam int IN_W  = 16;
    localparam int RES_W = 33;

    // working width of the operands (low bits of each field, sign-extended)
    localparam int OPW   = 16;
    localparam int PRD_W = 2 * OPW + 2;
    localparam int CNT_W = $clog2(OPW);

    typedef logic signed [OPW:0]       t_opnd;  // operand with room for negation
    typedef logic        [OPW-1:0]     t_mag;   // magnitude of an operand
    typedef logic signed [PRD_W-1:0]   t_prod;
    typedef logic signed [RES_W-1:0]   t_res;

    typedef enum logic [2:0] {
        OP_REDUCE = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_MUL    = 3'd3,
        OP_DIV    = 3'd4,
        OP_GT     = 3'd5,
        OP_LT     = 3'd6
    } t_op;

    // result of the shared subtractor
    typedef struct packed {
        logic          borrow;    // a < b
        logic [OPW:0]  diff;      // a - b, low bits
        t_mag          half_abs;  // |a - b| >> 1
    } t_sub_out;

    // take the low OPW bits of a field and sign-extend
    function automatic t_opnd sext_op(input logic [IN_W-1:0] v);
        logic [OPW-1:0] t;
        t_opnd          r;
        t = OPW'(v);
        r = signed'(t);
        return r;
    endfunction

    function automatic t_mag mag_of(input t_opnd x);
        t_opnd n;
        n = x[OPW] ? -x : x;
        return n[OPW-1:0];
    endfunction

    // magnitude q carrying a minus sign when neg is set
    function automatic t_opnd with_sign(input t_mag q, input logic neg);
        t_opnd v;
        v = $signed({1'b0, q});
        return neg ? -v : v;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/rau_shared_unit.sv
// Shared arithmetic unit: one subtract/compare with magnitude and one signed multiplier.
// Depends on rau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rau_shared_unit (
    input  logic [rau_pkg::OPW:0]  i_sub_a,
    input  logic [rau_pkg::OPW:0]  i_sub_b,
    output rau_pkg::t_sub_out      o_sub,
    input  rau_pkg::t_opnd         i_mul_a,
    input  rau_pkg::t_opnd         i_mul_b,
    output rau_pkg::t_prod         o_prod
);
    import rau_pkg::*;

    logic [OPW+1:0] d;
    logic [OPW+1:0] absd;

    // subtract with borrow out, plus |a - b| for the gcd step
    always_comb begin
        d              = {1'b0, i_sub_a} - {1'b0, i_sub_b};
        absd           = d[OPW+1] ? (~d + 1'b1) : d;
        o_sub.borrow   = d[OPW+1];
        o_sub.diff     = d[OPW:0];
        o_sub.half_abs = absd[OPW:1];
    end

    // signed product, full width
    assign o_prod = i_mul_a * i_mul_b;

endmodule

`default_nettype wire

### hw/rtl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: sequencer and operand registers.
// Depends on rau_pkg, rau_shared_unit and rational_arithmetic_unit_assert.svh.
//
// Usage:
//   Input channel (i_valid / o_ready) carries an operation code and two
//   fractions a_num/a_den, b_num/b_den. Output channel (o_valid / i_ready)
//   returns one beat per input: res_num, res_den, compare_true, error.
//   One item is worked at a time; o_ready is high only while the sequencer
//   is idle. Multiply, divide and compare take two multiplier passes;
//   rejected operands (zero denominator, bad code) go straight to the final
//   step. Reduce and add/subtract time is set by the binary gcd loop (one
//   subtract/shift step per cycle) and two restoring divisions by the gcd
//   (one quotient bit per cycle), all on the single shared subtractor.
//   The result sits in an output register, so a new beat is taken while the
//   previous result waits; a stalled receiver only holds the sequencer in
//   its final step once the next result is ready.
//   Reset (synchronous, active low) returns to idle and drops o_valid.
`timescale 1ns / 1ps
`default_nettype none

module rational_arithmetic_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [2:0]                  i_operation,
    input  logic signed [rau_pkg::IN_W-1:0]  i_a_num,
    input  logic signed [rau_pkg::IN_W-1:0]  i_a_den,
    input  logic signed [rau_pkg::IN_W-1:0]  i_b_num,
    input  logic signed [rau_pkg::IN_W-1:0]  i_b_den,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [rau_pkg::RES_W-1:0] o_res_num,
    output logic signed [rau_pkg::RES_W-1:0] o_res_den,
    output logic                        o_compare_true,
    output logic                        o_error
);
    import rau_pkg::*;

    `include "rational_arithmetic_unit_assert.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD,
        S_DIV1,
        S_DIV2,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_FIN
    } t_state;

    t_state            r_state;
    t_op               r_op;
    logic              r_err;
    t_opnd             r_an, r_ad, r_bn, r_bd;
    t_mag              r_m1, r_m2;
    t_mag              r_u, r_v;
    logic [CNT_W-1:0]  r_k;
    t_mag              r_g;
    t_mag              r_dnum, r_rem;
    logic [CNT_W-1:0]  r_cnt;
    t_mag              r_q1, r_q2;
    t_prod             r_p0, r_p1, r_p2;
    logic              r_ovalid;
    t_res              r_onum, r_oden;
    logic              r_ocmp, r_oerr;

    logic [OPW:0]      sub_a, sub_b;
    t_sub_out          sub_o;
    t_opnd             mul_a, mul_b;
    t_prod             prod;
    logic [OPW:0]      rem_shift;
    t_mag              n_quot;
    t_mag              n_rem;

    t_opnd             in_an, in_ad, in_bn, in_bd;
    logic              in_err;
    logic              in_fold;
    t_state            in_next;

    t_res              n_num, n_den;
    logic              n_cmp;
    logic              in_beat, fin_go;

    rau_shared_unit u_shared (
        .i_sub_a (sub_a),
        .i_sub_b (sub_b),
        .o_sub   (sub_o),
        .i_mul_a (mul_a),
        .i_mul_b (mul_b),
        .o_prod  (prod)
    );

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_ovalid;
    assign o_res_num      = r_onum;
    assign o_res_den      = r_oden;
    assign o_compare_true = r_ocmp;
    assign o_error        = r_oerr;

    assign in_beat = i_valid && o_ready;
    assign fin_go  = (r_state == S_FIN) && (!r_ovalid || i_ready);

    // operand decode and error screening at the input beat
    always_comb begin
        in_an   = sext_op(i_a_num);
        in_ad   = sext_op(i_a_den);
        in_bn   = sext_op(i_b_num);
        in_bd   = sext_op(i_b_den);
        in_fold = 1'b0;
        case (t_op'(i_operation))
            OP_REDUCE: begin
                in_err  = (in_ad == '0);
                in_next = S_GCD;
            end
            OP_ADD, OP_SUB: begin
                in_err  = (in_ad == '0) || (in_bd == '0);
                in_next = S_GCD;
            end
            OP_MUL: begin
                in_err  = (in_ad == '0) || (in_bd == '0);
                in_next = S_MUL1;
            end
            OP_DIV: begin
                in_err  = (in_ad == '0) || (in_bd == '0) || (in_bn == '0);
                in_next = S_MUL1;
            end
            OP_GT, OP_LT: begin
                in_err  = (in_ad == '0) || (in_bd == '0);
                in_fold = 1'b1;
                in_next = S_MUL1;
            end
            default: begin
                in_err  = 1'b1;
                in_next = S_FIN;
            end
        endcase
        if (in_err) begin
            in_next = S_FIN;
        end
    end

    // subtractor operands: gcd step or division trial
    always_comb begin
        rem_shift = {r_rem, r_dnum[OPW-1]};
        if (r_state == S_GCD) begin
            sub_a = {1'b0, r_u};
            sub_b = {1'b0, r_v};
        end else begin
            sub_a = rem_shift;
            sub_b = {1'b0, r_g};
        end
        n_quot = {r_dnum[OPW-2:0], ~sub_o.borrow};
        n_rem  = sub_o.borrow ? rem_shift[OPW-1:0] : sub_o.diff[OPW-1:0];
    end

    // multiplier operands per pass
    always_comb begin
        mul_a = r_an;
        mul_b = r_bn;
        case (r_state)
            S_MUL1: begin
                if (r_op == OP_ADD || r_op == OP_SUB) begin
                    mul_a = $signed({1'b0, r_q1});
                    mul_b = $signed({1'b0, r_m2});
                end else if (r_op == OP_MUL) begin
                    mul_a = r_an;
                    mul_b = r_bn;
                end else begin
                    mul_a = r_an;
                    mul_b = r_bd;
                end
            end
            S_MUL2: begin
                if (r_op == OP_ADD || r_op == OP_SUB) begin
                    mul_a = r_an;
                    mul_b = with_sign(r_q2, r_ad[OPW]);
                end else if (r_op == OP_MUL) begin
                    mul_a = r_ad;
                    mul_b = r_bd;
                end else begin
                    mul_a = r_ad;
                    mul_b = r_bn;
                end
            end
            S_MUL3: begin
                mul_a = r_bn;
                mul_b = with_sign(r_q1, r_bd[OPW]);
            end
            default: begin
                mul_a = r_an;
                mul_b = r_bn;
            end
        endcase
    end

    // final result assembly
    always_comb begin
        n_num = '0;
        n_den = '0;
        n_cmp = 1'b0;
        if (!r_err) begin
            case (r_op)
                OP_REDUCE: begin
                    n_num = RES_W'(with_sign(r_q1, r_an[OPW]));
                    n_den = RES_W'(with_sign(r_q2, r_ad[OPW]));
                end
                OP_ADD: begin
                    n_num = RES_W'(r_p1 + r_p2);
                    n_den = RES_W'(r_p0);
                end
                OP_SUB: begin
                    n_num = RES_W'(r_p1 - r_p2);
                    n_den = RES_W'(r_p0);
                end
                OP_MUL, OP_DIV: begin
                    n_num = RES_W'(r_p0);
                    n_den = RES_W'(r_p1);
                end
                OP_GT: n_cmp = (r_p0 > r_p1);
                OP_LT: n_cmp = (r_p0 < r_p1);
                default: n_cmp = 1'b0;
            endcase
        end
    end

    // sequencer, datapath registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            // a beat leaving while no new result is loaded
            if (r_ovalid && i_ready && !fin_go) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        r_op    <= t_op'(i_operation);
                        r_err   <= in_err;
                        r_an    <= (in_fold && in_ad[OPW]) ? -in_an : in_an;
                        r_ad    <= (in_fold && in_ad[OPW]) ? -in_ad : in_ad;
                        r_bn    <= (in_fold && in_bd[OPW]) ? -in_bn : in_bn;
                        r_bd    <= (in_fold && in_bd[OPW]) ? -in_bd : in_bd;
                        if (t_op'(i_operation) == OP_REDUCE) begin
                            r_m1 <= mag_of(in_an);
                            r_m2 <= mag_of(in_ad);
                            r_u  <= mag_of(in_an);
                            r_v  <= mag_of(in_ad);
                        end else begin
                            r_m1 <= mag_of(in_ad);
                            r_m2 <= mag_of(in_bd);
                            r_u  <= mag_of(in_ad);
                            r_v  <= mag_of(in_bd);
                        end
                        r_k     <= '0;
                        r_state <= in_next;
                    end
                end
                S_GCD: begin
                    // binary gcd, one step per cycle
                    if (r_u == '0 || r_v == '0) begin
                        r_g     <= (r_u | r_v) << r_k;
                        r_dnum  <= r_m1;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV1;
                    end else if (!r_u[0] && !r_v[0]) begin
                        r_u <= r_u >> 1;
                        r_v <= r_v >> 1;
                        r_k <= r_k + 1'b1;
                    end else if (!r_u[0]) begin
                        r_u <= r_u >> 1;
                    end else if (!r_v[0]) begin
                        r_v <= r_v >> 1;
                    end else if (!sub_o.borrow) begin
                        r_u <= sub_o.half_abs;
                    end else begin
                        r_v <= sub_o.half_abs;
                    end
                end
                S_DIV1: begin
                    // restoring division, one quotient bit per cycle
                    if (r_cnt == CNT_W'(OPW - 1)) begin
                        r_q1    <= n_quot;
                        r_dnum  <= r_m2;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV2;
                    end else begin
                        r_dnum <= n_quot;
                        r_rem  <= n_rem;
                        r_cnt  <= r_cnt + 1'b1;
                    end
                end
                S_DIV2: begin
                    r_dnum <= n_quot;
                    r_rem  <= n_rem;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(OPW - 1)) begin
                        r_q2    <= n_quot;
                        r_state <= (r_op == OP_REDUCE) ? S_FIN : S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_p0    <= prod;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_p1    <= prod;
                    r_state <= (r_op == OP_ADD || r_op == OP_SUB) ? S_MUL3 : S_FIN;
                end
                S_MUL3: begin
                    r_p2    <= prod;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (fin_go) begin
                        r_ovalid <= 1'b1;
                        r_onum   <= n_num;
                        r_oden   <= n_den;
                        r_ocmp   <= n_cmp;
                        r_oerr   <= r_err;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // checks on the sequencer and the result beat
    `RAU_ASSERT_SAME(a_err_zero, o_valid && o_error, o_res_num == '0 && o_res_den == '0 && !o_compare_true)
    `RAU_ASSERT_SAME(a_cmp_clean, o_valid && o_compare_true, !o_error && o_res_num == '0 && o_res_den == '0)
    `RAU_ASSERT_SAME(a_gcd_nonzero, r_state == S_GCD, r_u != '0 || r_v != '0)
    `RAU_ASSERT_SAME(a_div_nonzero, r_state == S_DIV1 || r_state == S_DIV2, r_g != '0)
    `RAU_ASSERT_NEXT(a_beat_starts, in_beat, r_state != S_IDLE)

endmodule

`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for rational_arithmetic_unit: directed and random fractions.
// Depends on rau_pkg and the RTL of rational_arithmetic_unit; predicts each result itself.
`timescale 1ns / 1ps

module tb_top;
    import rau_pkg::*;

    localparam logic [2:0]  OP_UNUSED = 3'd7;
    localparam logic [15:0] MOST_NEG  = 16'h8000;
    localparam logic [15:0] MOST_POS  = 16'h7FFF;
    localparam int          TAIL_CYCLES = 4 * OPW + 16;

    typedef struct {
        t_res num;
        t_res den;
        logic cmp;
        logic err;
    } t_frac_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_ready = 1'b0;
    logic [2:0]  i_operation = '0;
    logic signed [IN_W-1:0] i_a_num = '0;
    logic signed [IN_W-1:0] i_a_den = '0;
    logic signed [IN_W-1:0] i_b_num = '0;
    logic signed [IN_W-1:0] i_b_den = '0;
    logic        o_ready;
    logic        o_valid;
    logic signed [RES_W-1:0] o_res_num;
    logic signed [RES_W-1:0] o_res_den;
    logic        o_compare_true;
    logic        o_error;

    t_frac_result pending_results[$];
    int           mismatches = 0;
    bit           steady = 1'b0;   // no idling on either side while set

    rational_arithmetic_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_a_num        (i_a_num),
        .i_a_den        (i_a_den),
        .i_b_num        (i_b_num),
        .i_b_den        (i_b_den),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_res_num      (o_res_num),
        .o_res_den      (o_res_den),
        .o_compare_true (o_compare_true),
        .o_error        (o_error)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------

    // low OPW bits of a field, sign-extended
    function automatic longint to_operand(input logic [IN_W-1:0] v);
        longint t;
        t = longint'(v);
        t = (t <<< (64 - OPW)) >>> (64 - OPW);
        return t;
    endfunction

    function automatic longint abs_of(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    // Euclid on magnitudes
    function automatic longint gcd_of(input longint a, input longint b);
        longint t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic t_frac_result rational_result(input logic [2:0] op,
            input logic [IN_W-1:0] an_f, input logic [IN_W-1:0] ad_f,
            input logic [IN_W-1:0] bn_f, input logic [IN_W-1:0] bd_f);
        t_frac_result r;
        longint an, ad, bn, bd;
        longint ma, mb, g, lcm, ka, kb, lhs, rhs, rn, rd;
        an = to_operand(an_f);
        ad = to_operand(ad_f);
        bn = to_operand(bn_f);
        bd = to_operand(bd_f);
        rn = 0;
        rd = 0;
        r.cmp = 1'b0;
        r.err = 1'b0;
        case (op)
            OP_REDUCE: begin
                ma = abs_of(an);
                mb = abs_of(ad);
                g = gcd_of(ma, mb);
                if (ad == 0 || g == 0) begin
                    r.err = 1'b1;
                end else begin
                    rn = (an < 0) ? -(ma / g) : ma / g;
                    rd = (ad < 0) ? -(mb / g) : mb / g;
                end
            end
            OP_ADD, OP_SUB: begin
                if (ad == 0 || bd == 0) begin
                    r.err = 1'b1;
                end else begin
                    // common denominator is the lcm of the magnitudes
                    ma = abs_of(ad);
                    mb = abs_of(bd);
                    g = gcd_of(ma, mb);
                    lcm = (ma / g) * mb;
                    ka = (ad < 0) ? -(lcm / ma) : lcm / ma;
                    kb = (bd < 0) ? -(lcm / mb) : lcm / mb;
                    rn = (op == OP_ADD) ? an * ka + bn * kb : an * ka - bn * kb;
                    rd = lcm;
                end
            end
            OP_MUL: begin
                if (ad == 0 || bd == 0) begin
                    r.err = 1'b1;
                end else begin
                    rn = an * bn;
                    rd = ad * bd;
                end
            end
            OP_DIV: begin
                if (ad == 0 || bd == 0 || bn == 0) begin
                    r.err = 1'b1;
                end else begin
                    rn = an * bd;
                    rd = ad * bn;
                end
            end
            OP_GT, OP_LT: begin
                if (ad == 0 || bd == 0) begin
                    r.err = 1'b1;
                end else begin
                    // fold denominator signs into numerators, cross-multiply
                    lhs = ((ad < 0) ? -an : an) * abs_of(bd);
                    rhs = ((bd < 0) ? -bn : bn) * abs_of(ad);
                    r.cmp = (op == OP_GT) ? (lhs > rhs) : (lhs < rhs);
                end
            end
            default: r.err = 1'b1;
        endcase
        r.num = rn[RES_W-1:0];
        r.den = rd[RES_W-1:0];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // idle about 19 times in a hundred draws, never while steady
    function automatic bit idle_draw();
        return !steady && ($urandom_range(0, 99) < 19);
    endfunction

    // operand value: full range, small, extremes or powers of two
    function automatic logic [IN_W-1:0] pick_value(input bit nonzero);
        logic [IN_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = IN_W'($urandom);
            1: v = IN_W'(int'($urandom_range(0, 48)) - 24);
            2: begin
                case ($urandom_range(0, 4))
                    0: v = MOST_NEG;
                    1: v = MOST_POS;
                    2: v = '1;
                    3: v = IN_W'(1);
                    default: v = '0;
                endcase
            end
            default: begin
                v = IN_W'(1) << $urandom_range(0, IN_W - 1);
                if ($urandom_range(0, 1)) v = -v;
            end
        endcase
        if (nonzero && v == '0) v = IN_W'(1);
        return v;
    endfunction

    // one input beat; valid stays up from the previous beat unless we idle
    task automatic send_item(input logic [2:0] op,
            input logic [IN_W-1:0] an, input logic [IN_W-1:0] ad,
            input logic [IN_W-1:0] bn, input logic [IN_W-1:0] bd);
        if (idle_draw()) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while (idle_draw()) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_a_num     <= an;
        i_a_den     <= ad;
        i_b_num     <= bn;
        i_b_den     <= bd;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_results.push_back(rational_result(op, an, ad, bn, bd));
    endtask

    // mostly well-formed fractions, some zero denominators and bad codes
    task automatic send_random_item();
        logic [2:0]      op;
        logic [IN_W-1:0] ad, bd;
        op = ($urandom_range(0, 99) < 3) ? OP_UNUSED : 3'($urandom_range(0, 6));
        ad = ($urandom_range(0, 99) < 6) ? '0 : pick_value(1'b1);
        bd = ($urandom_range(0, 99) < 6) ? '0 : pick_value(1'b1);
        send_item(op, pick_value(1'b0), ad, pick_value(1'b0), bd);
    endtask

    // hold the sender until every pending result has arrived
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    task automatic test_directed();
        send_item(OP_REDUCE, 16'sd12, -16'sd18, 16'sd0, 16'sd1);
        send_item(OP_REDUCE, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS);
        send_item(OP_REDUCE, 16'sd0, 16'sd5, 16'sd3, 16'sd0);
        send_item(OP_REDUCE, 16'sd7, 16'sd0, 16'sd1, 16'sd1);        // zero denominator
        send_item(OP_REDUCE, 16'sd0, 16'sd0, 16'sd1, 16'sd1);        // zero gcd
        send_item(OP_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
        send_item(OP_ADD, MOST_POS, MOST_NEG, MOST_POS, MOST_POS);
        send_item(OP_SUB, MOST_NEG, MOST_POS, MOST_POS, MOST_NEG);
        send_item(OP_SUB, 16'sd5, 16'sd6, 16'sd1, 16'sd0);
        send_item(OP_MUL, MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG);
        send_item(OP_MUL, MOST_POS, 16'sd1, MOST_NEG, 16'sd1);
        send_item(OP_MUL, 16'sd3, 16'sd0, 16'sd4, 16'sd5);
        send_item(OP_DIV, 16'sd3, 16'sd4, -16'sd5, 16'sd7);
        send_item(OP_DIV, 16'sd3, 16'sd4, 16'sd0, 16'sd7);           // divide by zero fraction
        send_item(OP_DIV, MOST_NEG, MOST_POS, MOST_NEG, -16'sd1);
        send_item(OP_GT, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
        send_item(OP_GT, 16'sd1, -16'sd2, -16'sd1, 16'sd2);          // equal values
        send_item(OP_GT, 16'sd1, 16'sd0, 16'sd1, 16'sd2);
        send_item(OP_GT, 16'sd0, -16'sd5, 16'sd0, 16'sd3);
        send_item(OP_LT, MOST_NEG, 16'sd1, MOST_POS, 16'sd1);
        send_item(OP_LT, 16'sd2, 16'sd4, 16'sd1, 16'sd2);
        send_item(OP_LT, 16'sd1, -16'sd3, 16'sd1, -16'sd2);          // negative denominators
        send_item(OP_LT, MOST_POS, MOST_NEG, MOST_NEG, MOST_POS);
        send_item(OP_UNUSED, 16'sd1, 16'sd2, 16'sd3, 16'sd4);
        send_item(OP_UNUSED, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    endtask

    // a burst, a full drain with the sender held, then another burst
    task automatic test_drain_pause();
        repeat (20) send_random_item();
        wait_for_drain();
        repeat (20) send_random_item();
    endtask

    // long stretch without idling on either side
    task automatic test_back_to_back();
        steady = 1'b1;
        repeat (150) send_random_item();
        steady = 1'b0;
    endtask

    task automatic test_random();
        repeat (560) send_random_item();
    endtask

    // ---------------------------------------------------------------
    // Receiver and result check
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin
        i_ready <= !idle_draw();
    end

    always @(posedge i_clk) begin : check_beat
        t_frac_result exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing pending");
                mismatches++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_res_num !== exp_r.num) begin
                    $error("res_num: expected %0d, actual %0d", exp_r.num, o_res_num);
                    mismatches++;
                end
                if (o_res_den !== exp_r.den) begin
                    $error("res_den: expected %0d, actual %0d", exp_r.den, o_res_den);
                    mismatches++;
                end
                if (o_compare_true !== exp_r.cmp) begin
                    $error("compare_true: expected %0b, actual %0b",
                           exp_r.cmp, o_compare_true);
                    mismatches++;
                end
                if (o_error !== exp_r.err) begin
                    $error("error: expected %0b, actual %0b", exp_r.err, o_error);
                    mismatches++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_drain_pause();
        test_back_to_back();
        test_random();

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        mismatches += pending_results.size();

        if (mismatches == 0) begin
            $display("rational_arithmetic_unit regression: pass");
        end else begin
            $display("rational_arithmetic_unit regression: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("rational_arithmetic_unit regression: fail");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/rau_pkg.sv
hw/rtl/rau_shared_unit.sv
hw/rtl/rational_arithmetic_unit.sv
dv/tb_top.sv
